[design/tdt_pkg.sv]
`default_nettype none

package tdt_pkg;

  // Datapath widths.
  localparam int FB      = 30;          // fraction bits of the log2 result
  localparam int LOG_LAT = FB + 1;      // normalize stage plus one squaring per bit
  localparam int VW      = 16;          // sense voltage and reference
  localparam int RTW     = 26;          // pull-up plus series, milliohms
  localparam int NUMW    = 42;          // V times total pull-up
  localparam int NOMW    = 26;          // nominal, milliohms
  localparam int LW      = 38;          // signed log2 difference
  localparam int XW      = 36;          // magnitude of x in Q30
  localparam int TW      = 57;          // magnitude of the polynomial in Q60
  localparam int TL      = 29;          // low slice of t in the Horner multiply
  localparam int DW      = TW - 3;      // den56
  localparam int NW      = 64;          // dividend
  localparam int QW      = 16;          // quotient bits
  localparam int RW      = 70;          // divider remainder

  localparam logic [63:0]   LN2_Q64 = 64'hB17217F7D1CF79AC;
  localparam logic [TW-1:0] COEF_A  = 57'd3866917173195438;
  localparam logic [TW-1:0] COEF_B  = 57'd296283532861391;
  localparam logic [TW-1:0] COEF_C  = 57'd3020805374787;
  localparam logic [TW-1:0] COEF_D  = 57'd73592028798;

  localparam logic [15:0]        Q_OVER       = 16'd60083;
  localparam logic [QW:0]        KELVIN_CENTI = 17'd27315;
  localparam logic signed [15:0] TEMP_MIN     = -16'sd27315;
  localparam logic signed [15:0] TEMP_MAX     = 16'sd32767;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVER_REF = 2'd1,
    ST_ZERO_V   = 2'd2,
    ST_SAT      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_REFERENCE = 2'd0,
    REG_PULLUP    = 2'd1,
    REG_SERIES    = 2'd2,
    REG_NOMINAL   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic    valid;
    status_t early;
  } side_t;

  // Polynomial state handed from one Horner step to the next.
  typedef struct packed {
    logic          tneg;
    logic [TW-1:0] tmag;
    logic          xneg;
    logic [XW-1:0] xmag;
  } hst_t;

endpackage

`default_nettype wire

[design/tdt_log2.sv]
`default_nettype none

module tdt_log2 #(
  parameter int W = 16
) (
  input  wire                                clk,
  input  wire                                en,
  input  wire  [W-1:0]                       n,
  output logic [$clog2(W)+tdt_pkg::FB-1:0]   lg
);
  import tdt_pkg::*;

  localparam int KW = $clog2(W);

  logic [KW-1:0]  k_c;
  logic [KW-1:0]  sh_c;
  logic [W+FB:0]  wide_c;
  logic [FB:0]    ms [FB+1];
  logic [FB-1:0]  fs [FB+1];
  logic [KW-1:0]  ks [FB+1];
  logic [FB+1:0]  m2 [FB];
  logic [2*FB+1:0] sq [FB];

  // The msb index is the integer part; the value is left-justified so the
  // top FB+1 bits are the mantissa in [1,2).
  always_comb begin
    k_c = '0;
    for (int i = 0; i < W; i++) begin
      if (n[i]) k_c = KW'(i);
    end
    sh_c   = KW'(W - 1) - k_c;
    wide_c = {n, (FB + 1)'(0)} << sh_c;
  end

  always_comb begin
    for (int j = 0; j < FB; j++) begin
      sq[j] = (2 * FB + 2)'(ms[j]) * (2 * FB + 2)'(ms[j]);
      m2[j] = sq[j][2*FB+1:FB];
    end
  end

  // One fraction bit per stage: square, and renormalize when it reaches 2.
  always_ff @(posedge clk) begin
    if (en) begin
      ms[0] <= wide_c[W+FB -: FB+1];
      fs[0] <= '0;
      ks[0] <= k_c;
      for (int j = 0; j < FB; j++) begin
        ms[j+1] <= m2[j][FB+1] ? m2[j][FB+1:1] : m2[j][FB:0];
        fs[j+1] <= {fs[j][FB-2:0], m2[j][FB+1]};
        ks[j+1] <= ks[j];
      end
    end
  end

  assign lg = {ks[FB], fs[FB]};

endmodule

`default_nettype wire

[design/tdt_horner.sv]
`default_nettype none

module tdt_horner (
  input  wire                    clk,
  input  wire                    en,
  input  wire tdt_pkg::hst_t     hin,
  input  wire [tdt_pkg::TW-1:0]  coef,
  output tdt_pkg::hst_t          hout
);
  import tdt_pkg::*;

  localparam int SUMW = TW + XW + 1;

  logic [TL+XW-1:0]    a_pl;
  logic [TW-TL+XW-1:0] a_ph;
  logic                a_neg;
  logic                a_xneg;
  logic [XW-1:0]       a_xmag;

  logic [SUMW-1:0]     sum_c;
  logic [TW-1:0]       b_p;
  logic                b_neg;
  logic                b_xneg;
  logic [XW-1:0]       b_xmag;

  logic                big_c;
  logic [TW-1:0]       tmag_c;

  // Product of t and x, rounded half away from zero back to Q60, is taken
  // on magnitudes; the sign is applied when the coefficient is added.
  assign sum_c = SUMW'({a_ph, TL'(0)}) + SUMW'(a_pl) + (SUMW'(1) << (FB - 1));

  always_comb begin
    big_c = b_p > coef;
    if (!b_neg) begin
      tmag_c = coef + b_p;
    end else if (big_c) begin
      tmag_c = b_p - coef;
    end else begin
      tmag_c = coef - b_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_pl   <= (TL + XW)'(hin.tmag[TL-1:0]) * (TL + XW)'(hin.xmag);
      a_ph   <= (TW - TL + XW)'(hin.tmag[TW-1:TL]) * (TW - TL + XW)'(hin.xmag);
      a_neg  <= hin.tneg ^ hin.xneg;
      a_xneg <= hin.xneg;
      a_xmag <= hin.xmag;

      b_p    <= sum_c[FB +: TW];
      b_neg  <= a_neg;
      b_xneg <= a_xneg;
      b_xmag <= a_xmag;

      hout.tneg <= b_neg && big_c;
      hout.tmag <= tmag_c;
      hout.xneg <= b_xneg;
      hout.xmag <= b_xmag;
    end
  end

endmodule

`default_nettype wire

[design/thermistor_divider_to_temperature.sv]
`default_nettype none

// Channel  Handshake                  Payload
// -------  -------------------------  ----------------------------------
// sense    sense_valid / sense_stall  sense_voltage
// result   result_valid/result_stall  temperature_centi, status
// config   write_enable               register_index, write_data
//
// One item is taken every cycle while sense_stall is low. The depth is set
// mostly by the three log2 units, which square once per stage for 30
// stages, and by the 16-stage quotient unit. Reset clears the valid bits,
// including the skid flag, and loads the default register values. A result
// stall freezes the whole pipeline once the one-entry skid register behind
// the output register is full; sense_stall is that skid's full flag.

module thermistor_divider_to_temperature (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       write_enable,
  input  wire [1:0]                 register_index,
  input  wire [15:0]                write_data,
  input  wire                       sense_valid,
  output logic                      sense_stall,
  input  wire [tdt_pkg::VW-1:0]     sense_voltage,
  output logic                      result_valid,
  input  wire                       result_stall,
  output logic signed [15:0]        temperature_centi,
  output logic [1:0]                status
);
  import tdt_pkg::*;

  localparam int NST = 2 + LOG_LAT + 4 + 9 + 3 + QW;
  localparam int PW  = XW + 32;
  localparam int SW  = PW + 33;
  localparam int LGN = $clog2(NUMW) + FB;
  localparam int LGD = $clog2(VW) + FB;
  localparam int LGM = $clog2(NOMW) + FB;

  // Configuration registers.
  logic [15:0] reference_voltage;
  logic [15:0] pullup_ohms;
  logic [9:0]  series_milliohms;
  logic [15:0] nominal_ohms;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_voltage <= 16'd33000;
      pullup_ohms       <= 16'd10000;
      series_milliohms  <= 10'd60;
      nominal_ohms      <= 16'd10000;
    end else if (write_enable) begin
      unique case (reg_index_t'(register_index))
        REG_REFERENCE: reference_voltage <= write_data;
        REG_PULLUP:    pullup_ohms       <= write_data;
        REG_SERIES:    series_milliohms  <= write_data[9:0];
        REG_NOMINAL:   nominal_ohms      <= write_data;
        default:       reference_voltage <= reference_voltage;
      endcase
    end
  end

  logic adv;
  logic accept;
  logic skid_valid;

  assign adv         = !skid_valid;
  assign sense_stall = skid_valid;
  assign accept      = sense_valid && !skid_valid;

  // Front end: fault checks and the resistances in milliohms.
  logic [RTW-1:0]  rtot_c;
  logic [NOMW-1:0] nomk_c;
  status_t         early_c;

  always_comb begin
    rtot_c = RTW'(pullup_ohms) * RTW'(1000) + RTW'(series_milliohms);
    nomk_c = (nominal_ohms == 16'd0) ? NOMW'(1000) : NOMW'(nominal_ohms) * NOMW'(1000);
    if (sense_voltage >= reference_voltage) begin
      early_c = ST_OVER_REF;
    end else if (sense_voltage == '0) begin
      early_c = ST_ZERO_V;
    end else if (rtot_c == '0) begin
      early_c = ST_SAT;
    end else begin
      early_c = ST_OK;
    end
  end

  side_t sd [NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NST; j++) sd[j] <= '0;
    end else if (adv) begin
      sd[0] <= '{valid: accept, early: early_c};
      for (int j = 1; j < NST; j++) sd[j] <= sd[j-1];
    end
  end

  logic [VW-1:0]   p1_v;
  logic [RTW-1:0]  p1_rtot;
  logic [VW-1:0]   p1_dvd;
  logic [NOMW-1:0] p1_nomk;
  logic [NUMW-1:0] p2_num;
  logic [VW-1:0]   p2_dvd;
  logic [NOMW-1:0] p2_nomk;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_v    <= sense_voltage;
      p1_rtot <= rtot_c;
      p1_dvd  <= reference_voltage - sense_voltage;
      p1_nomk <= nomk_c;
      p2_num  <= NUMW'(p1_v) * NUMW'(p1_rtot);
      p2_dvd  <= p1_dvd;
      p2_nomk <= p1_nomk;
    end
  end

  logic [LGN-1:0] lg_num;
  logic [LGD-1:0] lg_dvd;
  logic [LGM-1:0] lg_nomk;

  tdt_log2 #(.W(NUMW)) u_log_num  (.clk(clk), .en(adv), .n(p2_num),  .lg(lg_num));
  tdt_log2 #(.W(VW))   u_log_dvd  (.clk(clk), .en(adv), .n(p2_dvd),  .lg(lg_dvd));
  tdt_log2 #(.W(NOMW)) u_log_nomk (.clk(clk), .en(adv), .n(p2_nomk), .lg(lg_nomk));

  // x = ln(R / nominal) = ln2 * (log2 num - log2 dvd - log2 nomk), kept as
  // sign and magnitude for the Horner steps.
  logic [LW-1:0] xl2;
  logic [LW-1:0] xabs_c;
  logic [XW-1:0] x_abs;
  logic          neg35;
  logic [PW-1:0] ph;
  logic [PW-1:0] pl;
  logic          neg36;
  logic [SW-1:0] s_c;
  logic [XW-1:0] x_mag;
  logic          x_neg;

  assign xabs_c = xl2[LW-1] ? (~xl2 + LW'(1)) : xl2;
  assign s_c    = SW'({ph, 32'd0}) + SW'(pl) + (SW'(1) << 63);

  always_ff @(posedge clk) begin
    if (adv) begin
      xl2   <= LW'(lg_num) - LW'(lg_dvd) - LW'(lg_nomk);
      x_abs <= xabs_c[XW-1:0];
      neg35 <= xl2[LW-1];
      ph    <= PW'(x_abs) * PW'(LN2_Q64[63:32]);
      pl    <= PW'(x_abs) * PW'(LN2_Q64[31:0]);
      neg36 <= neg35;
      x_mag <= s_c[64 +: XW];
      x_neg <= neg36;
    end
  end

  hst_t h0, h1, h2, h3;

  assign h0 = '{tneg: 1'b0, tmag: COEF_D, xneg: x_neg, xmag: x_mag};

  tdt_horner u_step_c (.clk(clk), .en(adv), .hin(h0), .coef(COEF_C), .hout(h1));
  tdt_horner u_step_b (.clk(clk), .en(adv), .hin(h1), .coef(COEF_B), .hout(h2));
  tdt_horner u_step_a (.clk(clk), .en(adv), .hin(h2), .coef(COEF_A), .hout(h3));

  // Reciprocal: q = (100 * 2^56 + den/2) / den, with the overflow test done
  // by one constant multiply so that only 16 quotient bits remain.
  logic [TW:0]    den_c;
  logic [DW-1:0]  f_den;
  logic [NW-1:0]  f_num;
  logic           f_tneg;
  logic [DW-1:0]  g_den;
  logic [NW-1:0]  g_num;
  logic [RW-1:0]  g_prod;
  logic           g_tneg;

  logic [RW-1:0]  dr    [QW+1];
  logic [QW-1:0]  dq    [QW+1];
  logic [DW-1:0]  dden  [QW+1];
  logic           dtneg [QW+1];
  logic           dovf  [QW+1];
  logic [RW:0]    trial [QW];

  assign den_c = (TW + 1)'(h3.tmag) + (TW + 1)'(8);

  always_comb begin
    for (int j = 0; j < QW; j++) begin
      trial[j] = {1'b0, dr[j]} - ({1'b0, RW'(dden[j])} << (QW - 1 - j));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_den  <= den_c[TW:4];
      f_num  <= (NW'(100) << 56) + NW'(den_c[TW:5]);
      f_tneg <= h3.tneg;
      g_den  <= f_den;
      g_num  <= f_num;
      g_prod <= RW'(f_den) * RW'(Q_OVER);
      g_tneg <= f_tneg;
      dr[0]    <= RW'(g_num);
      dq[0]    <= '0;
      dden[0]  <= g_den;
      dtneg[0] <= g_tneg;
      dovf[0]  <= RW'(g_num) >= g_prod;
      for (int j = 0; j < QW; j++) begin
        dr[j+1]    <= trial[j][RW] ? dr[j] : trial[j][RW-1:0];
        dq[j+1]    <= dq[j] | (QW'(!trial[j][RW]) << (QW - 1 - j));
        dden[j+1]  <= dden[j];
        dtneg[j+1] <= dtneg[j];
        dovf[j+1]  <= dovf[j];
      end
    end
  end

  logic signed [15:0] res_temp;
  status_t            res_status;
  logic [QW:0]        diff_c;

  assign diff_c = {1'b0, dq[QW]} - KELVIN_CENTI;

  always_comb begin
    case (sd[NST-1].early) inside
      ST_OVER_REF, ST_ZERO_V: begin
        res_temp   = 16'sd0;
        res_status = sd[NST-1].early;
      end
      ST_SAT: begin
        res_temp   = TEMP_MIN;
        res_status = ST_SAT;
      end
      default: begin
        if (dtneg[QW]) begin
          res_temp   = TEMP_MIN;
          res_status = ST_SAT;
        end else if (dovf[QW]) begin
          res_temp   = TEMP_MAX;
          res_status = ST_SAT;
        end else begin
          res_temp   = $signed(diff_c[15:0]);
          res_status = ST_OK;
        end
      end
    endcase
  end

  // Output register with a one-entry skid behind it.
  logic signed [15:0] skid_temp;
  logic [1:0]         skid_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= sd[NST-1].valid;
      end
    end else if (sd[NST-1].valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_valid) begin
        temperature_centi <= skid_temp;
        status            <= skid_status;
      end else begin
        temperature_centi <= res_temp;
        status            <= res_status;
      end
    end else if (!skid_valid) begin
      skid_temp   <= res_temp;
      skid_status <= res_status;
    end
  end

endmodule

`default_nettype wire

[design/tdt_check.sv]
`default_nettype none

module tdt_check (
  input wire               clk,
  input wire               rst,
  input wire               sense_valid,
  input wire               sense_stall,
  input wire               result_valid,
  input wire               result_stall,
  input wire signed [15:0] temperature_centi,
  input wire [1:0]         status
);
  import tdt_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temperature_centi)
      && $stable(status))
    else $error("result item changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == ST_OVER_REF || status == ST_ZERO_V)
      |-> temperature_centi == 16'sd0)
    else $error("fault item carries a nonzero temperature");

  a_sat_rail: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_SAT
      |-> temperature_centi == TEMP_MIN || temperature_centi == TEMP_MAX)
    else $error("saturated item is not on a rail");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(sense_stall) |-> $past(result_valid && result_stall))
    else $error("input stalled without a stalled result");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    sense_stall && sense_valid |-> result_valid)
    else $error("input stalled while the output register is empty");

endmodule

bind thermistor_divider_to_temperature tdt_check u_tdt_check (
  .clk               (clk),
  .rst               (rst),
  .sense_valid       (sense_valid),
  .sense_stall       (sense_stall),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .temperature_centi (temperature_centi),
  .status            (status)
);

`default_nettype wire

[sim/thermistor_divider_to_temperature_tb.sv]
`timescale 1ns / 100ps

module thermistor_divider_to_temperature_tb;
  import tdt_pkg::*;

  typedef struct {
    logic signed [15:0] temp;
    status_t            st;
  } reading_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               write_enable = 1'b0;
  logic [1:0]         register_index = REG_REFERENCE;
  logic [15:0]        write_data = '0;
  logic               sense_valid = 1'b0;
  logic               sense_stall;
  logic [15:0]        sense_voltage = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [15:0] temperature_centi;
  logic [1:0]         status;

  // Shadow copies of the block's registers.
  logic [15:0] vref_q, pullup_q, nominal_q;
  logic [9:0]  series_q;

  logic [15:0] voltage_queue[$];
  reading_t    reading_queue[$];
  int          errors = 0;
  int          sent = 0;
  int          checked = 0;
  int          configs = 0;
  bit          quiet = 0;
  int          send_gap = 0;
  int          recv_gap = 0;

  always #5 clk = ~clk;

  thermistor_divider_to_temperature u_dut (
    .clk(clk), .rst(rst),
    .write_enable(write_enable), .register_index(register_index), .write_data(write_data),
    .sense_valid(sense_valid), .sense_stall(sense_stall), .sense_voltage(sense_voltage),
    .result_valid(result_valid), .result_stall(result_stall),
    .temperature_centi(temperature_centi), .status(status)
  );

  // Fixed-point log2 in Q30: integer part from the msb, fraction by squaring.
  function automatic logic [63:0] log2_fixed(logic [63:0] n);
    int unsigned  k;
    logic [63:0]  m;
    logic [63:0]  frac;
    k = 63;
    frac = '0;
    while (k > 0 && n[k] == 1'b0) k--;
    m = (k >= 30) ? (n >> (k - 30)) : (n << (30 - k));
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return (64'(k) << 30) | frac;
  endfunction

  function automatic longint coef_fixed(logic [127:0] num, logic [127:0] den);
    logic [127:0] q;
    q = (num << 61) / den;
    return longint'((q + 1) >> 1);
  endfunction

  // Signed product scaled down by 2^30, rounded half away from zero.
  function automatic longint mul_q30(longint a, longint b);
    logic [127:0] ua, ub, p;
    ua = (a < 0) ? 128'(-a) : 128'(a);
    ub = (b < 0) ? 128'(-b) : 128'(b);
    p = (ua * ub + (128'd1 << 29)) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
  endfunction

  function automatic reading_t convert_voltage(logic [15:0] v);
    reading_t     r;
    logic [63:0]  num, dvd, nomk;
    longint       xl2, x, t;
    logic [127:0] ax, den56, q;
    r.temp = '0;
    r.st = ST_OK;
    if (v >= vref_q) begin
      r.st = ST_OVER_REF;
    end else if (v == 0) begin
      r.st = ST_ZERO_V;
    end else begin
      num = 64'(v) * (64'(pullup_q) * 1000 + 64'(series_q));
      if (num == 0) begin
        r.temp = TEMP_MIN;
        r.st = ST_SAT;
      end else begin
        dvd = 64'(vref_q - v);
        nomk = ((nominal_q == 0) ? 64'd1 : 64'(nominal_q)) * 1000;
        xl2 = longint'(log2_fixed(num)) - longint'(log2_fixed(dvd))
              - longint'(log2_fixed(nomk));
        ax = (xl2 < 0) ? 128'(-xl2) : 128'(xl2);
        ax = (ax * 128'h B17217F7D1CF79AC + (128'd1 << 63)) >> 64;
        x = (xl2 < 0) ? -longint'(ax) : longint'(ax);
        t = coef_fixed(6383091, 128'd100000000000000);
        t = mul_q30(t, x) + coef_fixed(2620131, 128'd1000000000000);
        t = mul_q30(t, x) + coef_fixed(256985, 128'd1000000000);
        t = mul_q30(t, x) + coef_fixed(3354016, 128'd1000000000);
        if (t < 0) begin
          r.temp = TEMP_MIN;
          r.st = ST_SAT;
        end else begin
          den56 = (128'(t) + 8) >> 4;
          if (den56 == 0) begin
            r.temp = TEMP_MAX;
            r.st = ST_SAT;
          end else begin
            q = ((128'd100 << 56) + den56 / 2) / den56;
            if (q > 128'd60082) begin
              r.temp = TEMP_MAX;
              r.st = ST_SAT;
            end else begin
              r.temp = 16'(q) - 16'sd27315;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // Sender: a new item is taken from the queue only when the previous one was accepted.
  always @(posedge clk) begin
    if (sense_valid && !sense_stall) begin
      reading_queue.push_back(convert_voltage(sense_voltage));
      sent++;
    end
    if (!(sense_valid && sense_stall)) begin
      if (send_gap > 0) begin
        send_gap--;
        sense_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 7);
        sense_valid <= 1'b0;
      end else if (voltage_queue.size() > 0 && !rst) begin
        sense_valid <= 1'b1;
        sense_voltage <= voltage_queue.pop_front();
      end else begin
        sense_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each result against the oldest prediction, stall in bursts.
  always @(posedge clk) begin
    reading_t want;
    if (result_valid && !result_stall) begin
      if (reading_queue.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: temp %0d status %0d",
                 $time, temperature_centi, status);
      end else begin
        want = reading_queue.pop_front();
        checked++;
        if (temperature_centi !== want.temp) begin
          errors++;
          $display("%0t: temperature_centi expected %0d actual %0d",
                   $time, want.temp, temperature_centi);
        end
        if (status !== want.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
        end
      end
    end
    if (recv_gap > 0) begin
      recv_gap--;
      result_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 7);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(posedge clk);
    write_enable <= 1'b1;
    register_index <= idx;
    write_data <= val;
    @(posedge clk);
    write_enable <= 1'b0;
    case (idx)
      REG_REFERENCE: vref_q = val;
      REG_PULLUP:    pullup_q = val;
      REG_SERIES:    series_q = val[9:0];
      default:       nominal_q = val;
    endcase
    configs++;
  endtask

  // Every pending item accepted and every result back, then a margin for the pipe.
  task automatic drain();
    while (voltage_queue.size() > 0 || sense_valid || reading_queue.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic setup(logic [15:0] vr, logic [15:0] pu, logic [15:0] se, logic [15:0] no);
    drain();
    write_reg(REG_REFERENCE, vr);
    write_reg(REG_PULLUP, pu);
    write_reg(REG_SERIES, se);
    write_reg(REG_NOMINAL, no);
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0)
        voltage_queue.push_back(16'($urandom));
      else if (vref_q > 1)
        voltage_queue.push_back(16'($urandom_range(1, vref_q - 1)));
      else
        voltage_queue.push_back(16'($urandom_range(0, 50000)));
    end
  endtask

  initial begin
    vref_q = 16'd33000;
    pullup_q = 16'd10000;
    series_q = 10'd60;
    nominal_q = 16'd10000;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: edges of the voltage range at the reset setting.
    foreach (voltage_queue[i]) ;
    voltage_queue.push_back(16'd0);
    voltage_queue.push_back(16'd1);
    voltage_queue.push_back(16'd16500);
    voltage_queue.push_back(16'd32999);
    voltage_queue.push_back(16'd33000);
    voltage_queue.push_back(16'd33001);
    voltage_queue.push_back(16'd50000);
    voltage_queue.push_back(16'hFFFF);
    voltage_queue.push_back(16'h5555);
    voltage_queue.push_back(16'h2AAA);
    // Tiny thermistor resistance against a huge nominal: hot side saturates.
    setup(16'd50000, 16'd1, 16'd0, 16'd65535);
    voltage_queue.push_back(16'd1);
    voltage_queue.push_back(16'd2);
    voltage_queue.push_back(16'd49999);
    // No pull-up at all: resistance reads zero.
    setup(16'd50000, 16'd0, 16'd0, 16'd1);
    voltage_queue.push_back(16'd100);
    voltage_queue.push_back(16'd49999);
    // Huge resistance against nominal zero (read as one ohm): cold side.
    setup(16'd50000, 16'd65535, 16'd1000, 16'd0);
    voltage_queue.push_back(16'd49999);
    voltage_queue.push_back(16'd1);
    voltage_queue.push_back(16'd25000);
    // Reference of one: every nonzero voltage is at or above it.
    setup(16'd1, 16'd10000, 16'hFFFF, 16'd10000);
    voltage_queue.push_back(16'd0);
    voltage_queue.push_back(16'd1);
    voltage_queue.push_back(16'd7);

    // Random phases; each boundary lets the block drain completely.
    for (int p = 0; p < 8; p++) begin
      if (p == 0)
        setup(16'd33000, 16'd10000, 16'd60, 16'd10000);
      else
        setup(16'($urandom_range(1, 50000)), 16'($urandom_range(0, 65535)),
              16'($urandom), 16'($urandom_range(0, 65535)));
      push_random(130);
    end
    setup(16'd50000, 16'd4700, 16'd500, 16'd10000);
    quiet = 1;
    push_random(40);
    drain();

    $display("Converted %0d voltages over %0d register writes, %0d results checked.",
             sent, configs, checked);
    if (errors == 0)
      $display("thermistor_divider_to_temperature: match");
    else
      $display("thermistor_divider_to_temperature: mismatch");
    $finish;
  end

  initial begin
    #50ms;
    $display("thermistor_divider_to_temperature: mismatch");
    $finish;
  end

endmodule
